/* sv/xnde_pkg.sv */
package xnde_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned CAP_W = 32;
	localparam int unsigned LEN_W = 7;
	localparam int unsigned CNT_W = 6;
	localparam int unsigned NIBBLES = 16;
	localparam int unsigned MAX_CODE_BITS = 68;
	localparam int unsigned NIBBLE_CAP = 15;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 32'd65536;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef struct packed {
		logic [WORD_W-1:0] word0;
		logic [WORD_W-1:0] word1;
		logic [1:0] nwords;
		logic status;
		logic [LEN_W-1:0] code_length;
	} entry_t;

endpackage

/* sv/xnde_front.sv */
module xnde_front (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [xnde_pkg::CAP_W-1:0] cfg_wdata,
	input logic accept,
	input logic op,
	input logic [xnde_pkg::WORD_W-1:0] value_bits,
	input logic [xnde_pkg::WORD_W-1:0] predictor_bits,
	output xnde_pkg::entry_t entry
);

	logic [xnde_pkg::CAP_W-1:0] capacity_q;
	logic [xnde_pkg::CAP_W-1:0] used_bits_q;
	logic [xnde_pkg::WORD_W-1:0] pending_word_q;
	logic [xnde_pkg::CNT_W-1:0] pending_count_q;

	logic [xnde_pkg::WORD_W-1:0] diff;
	logic [3:0] cnt;
	logic [xnde_pkg::LEN_W-1:0] len;
	logic [xnde_pkg::CAP_W-1:0] room;
	logic overflow;
	logic [xnde_pkg::MAX_CODE_BITS-1:0] code;
	logic [2*xnde_pkg::WORD_W+3:0] acc;
	logic [7:0] total;

	always_comb begin
		diff = value_bits ^ predictor_bits;
		cnt = 4'(xnde_pkg::NIBBLE_CAP);
		for (int i = 0; i < int'(xnde_pkg::NIBBLES); i++) begin
			if (diff[4*i +: 4] != 4'd0) begin
				cnt = 4'(int'(xnde_pkg::NIBBLES) - 1 - i);
			end
		end
		len = 7'(xnde_pkg::MAX_CODE_BITS) - {1'b0, cnt, 2'b00};
		room = (capacity_q >= used_bits_q) ? capacity_q - used_bits_q : '0;
		overflow = room < {25'd0, len};
		code = {diff, cnt};
		acc = {68'd0, pending_word_q} | ({64'd0, code} << pending_count_q);
		total = {2'b00, pending_count_q} + {1'b0, len};
	end

	always_comb begin
		entry = '0;
		if (op == xnde_pkg::OP_FLUSH) begin
			entry.word0 = pending_word_q;
			entry.nwords = (pending_count_q != '0) ? 2'd1 : 2'd0;
		end else if (overflow) begin
			entry.status = 1'b1;
		end else begin
			entry.code_length = len;
			entry.word0 = acc[63:0];
			entry.word1 = acc[127:64];
			if (total >= 8'd128) begin
				entry.nwords = 2'd2;
			end else if (total >= 8'd64) begin
				entry.nwords = 2'd1;
			end else begin
				entry.nwords = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= xnde_pkg::CAPACITY_RESET;
			used_bits_q <= '0;
			pending_word_q <= '0;
			pending_count_q <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				if (op == xnde_pkg::OP_FLUSH) begin
					pending_word_q <= '0;
					pending_count_q <= '0;
				end else if (!overflow) begin
					used_bits_q <= used_bits_q + {25'd0, len};
					if (total >= 8'd128) begin
						pending_word_q <= {60'd0, acc[131:128]};
						pending_count_q <= 6'(total - 8'd128);
					end else if (total >= 8'd64) begin
						pending_word_q <= acc[127:64];
						pending_count_q <= 6'(total - 8'd64);
					end else begin
						pending_word_q <= acc[63:0];
						pending_count_q <= 6'(total);
					end
				end
			end
		end
	end

endmodule

/* sv/xnde_queue.sv */
module xnde_queue #(
	parameter int unsigned DEPTH = xnde_pkg::QUEUE_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input xnde_pkg::entry_t push_data,
	input logic pop,
	output logic full,
	output logic head_valid,
	output xnde_pkg::entry_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	xnde_pkg::entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/xnde_back.sv */
module xnde_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input xnde_pkg::entry_t head,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [xnde_pkg::WORD_W-1:0] packed_word,
	output logic word_valid,
	output logic status,
	output logic [xnde_pkg::LEN_W-1:0] code_length,
	output logic last
);

	logic out_valid_q;
	logic phase_q;
	logic load;
	logic second_pending;

	assign load = head_valid && (!out_valid_q || !out_stall);
	assign second_pending = (head.nwords == 2'd2) && !phase_q;
	assign pop = load && !second_pending;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q <= second_pending;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			packed_word <= phase_q ? head.word1 :
				((head.nwords != 2'd0) ? head.word0 : '0);
			word_valid <= head.nwords != 2'd0;
			status <= head.status;
			code_length <= head.code_length;
			last <= !second_pending;
		end
	end

endmodule

/* sv/xor_nibble_double_encoder.sv */
// A result word is written into the result queue and then into the output register.
// Throughput: one input word per cycle while the queue is not full; an input word that
// completes two stream words gives two results in turn from the output register, and a
// result queue of QUEUE_DEPTH entries absorbs that and any output stall.
// Reset: arst_n clears the stream state and the queue and sets capacity to 65536 bits.
module xor_nibble_double_encoder #(
	parameter int unsigned QUEUE_DEPTH = xnde_pkg::QUEUE_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [xnde_pkg::CAP_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input logic op,
	input logic [xnde_pkg::WORD_W-1:0] value_bits,
	input logic [xnde_pkg::WORD_W-1:0] predictor_bits,
	output logic out_valid,
	input logic out_stall,
	output logic [xnde_pkg::WORD_W-1:0] packed_word,
	output logic word_valid,
	output logic status,
	output logic [xnde_pkg::LEN_W-1:0] code_length,
	output logic last
);

	xnde_pkg::entry_t front_entry;
	xnde_pkg::entry_t head;
	logic full;
	logic head_valid;
	logic pop;
	logic accept;

	assign in_stall = full;
	assign accept = in_valid && !full;

	xnde_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept(accept),
		.op(op),
		.value_bits(value_bits),
		.predictor_bits(predictor_bits),
		.entry(front_entry)
	);

	xnde_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_data(front_entry),
		.pop(pop),
		.full(full),
		.head_valid(head_valid),
		.head(head)
	);

	xnde_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.packed_word(packed_word),
		.word_valid(word_valid),
		.status(status),
		.code_length(code_length),
		.last(last)
	);

	// A non-final result is always the first of two completed words.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> word_valid && !status)
		else $error("non-final result without a word");

	// An overflowed value appends nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !word_valid && code_length == '0 && last)
		else $error("overflow result carries data");

	// Appended lengths lie between 8 and 68 bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_length != '0 |-> code_length >= 7'd8 && code_length <= 7'd68)
		else $error("code length out of range");

	// Without a completed word the word field is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !word_valid |-> packed_word == '0)
		else $error("stale word on output");

endmodule

/* verif/xor_nibble_double_encoder_test.sv */
`timescale 1ns / 100ps

module xor_nibble_double_encoder_test;

	localparam int unsigned WORD_W = xnde_pkg::WORD_W;
	localparam int unsigned CAP_W = xnde_pkg::CAP_W;
	localparam int unsigned LEN_W = xnde_pkg::LEN_W;
	localparam int unsigned NIBBLES = xnde_pkg::NIBBLES;
	localparam int unsigned NIBBLE_CAP = xnde_pkg::NIBBLE_CAP;
	localparam int unsigned MAX_CODE_BITS = xnde_pkg::MAX_CODE_BITS;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = xnde_pkg::CAPACITY_RESET;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic wvalid;
		logic stat;
		logic [LEN_W-1:0] clen;
		logic lastf;
	} stream_result_t;

	typedef struct packed {
		logic set_cap;
		logic [CAP_W-1:0] cap;
		xnde_pkg::op_t op;
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] pred;
		logic typed;
		stream_result_t res;
	} script_row_t;

	localparam int unsigned SCRIPT_ROWS = 19;
	localparam int unsigned PHASES = 10;
	localparam int unsigned PHASE_WORDS = 50;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam logic [WORD_W-1:0] ONES = '1;
	localparam stream_result_t NO_WORD = '{64'd0, 1'b0, 1'b0, 7'd0, 1'b1};
	localparam stream_result_t OVERFLOWED = '{64'd0, 1'b0, 1'b1, 7'd0, 1'b1};
	localparam stream_result_t SHORT_CODE = '{64'd0, 1'b0, 1'b0, 7'd8, 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = xnde_pkg::OP_ENCODE;
	logic [WORD_W-1:0] value_bits = '0;
	logic [WORD_W-1:0] predictor_bits = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [WORD_W-1:0] packed_word;
	logic word_valid;
	logic status;
	logic [LEN_W-1:0] code_length;
	logic last;

	logic [CAP_W-1:0] cap_bits;
	int unsigned bits_used;
	logic [WORD_W-1:0] acc_word;
	int unsigned acc_count;

	stream_result_t due_q[$];
	script_row_t script[SCRIPT_ROWS];
	int unsigned mismatches = 0;
	bit quiet_tx = 1'b0;
	bit quiet_rx = 1'b0;
	int stall_left = 0;

	xor_nibble_double_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.value_bits(value_bits),
		.predictor_bits(predictor_bits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.packed_word(packed_word),
		.word_valid(word_valid),
		.status(status),
		.code_length(code_length),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned lead_nibbles(input logic [WORD_W-1:0] d);
		int unsigned n;
		bit hit;
		n = 0;
		hit = 1'b0;
		for (int i = NIBBLES - 1; i >= 0; i--) begin
			if (!hit && d[4*i +: 4] == 4'd0)
				n++;
			else
				hit = 1'b1;
		end
		return (n > NIBBLE_CAP) ? NIBBLE_CAP : n;
	endfunction

	function automatic bit append_bits(input logic [WORD_W-1:0] b, input int unsigned w,
			output logic [WORD_W-1:0] done);
		logic [WORD_W-1:0] hi;
		int unsigned pos;
		hi = '0;
		done = '0;
		pos = acc_count;
		if (w < WORD_W)
			b &= (64'd1 << w) - 64'd1;
		acc_word |= b << pos;
		if (pos != 0)
			hi = b >> (WORD_W - pos);
		pos += w;
		if (pos >= WORD_W) begin
			done = acc_word;
			acc_word = hi;
			acc_count = pos - WORD_W;
			return 1'b1;
		end
		acc_count = pos;
		return 1'b0;
	endfunction

	function automatic void encode_step(input xnde_pkg::op_t o, input logic [WORD_W-1:0] v,
			input logic [WORD_W-1:0] p, input bit keep);
		logic [WORD_W-1:0] diff;
		logic [WORD_W-1:0] w;
		int unsigned cnt;
		int unsigned len;
		int unsigned room;
		int n;
		stream_result_t r[2];
		n = 0;
		if (o == xnde_pkg::OP_FLUSH) begin
			r[0] = '{(acc_count != 0) ? acc_word : 64'd0, acc_count != 0, 1'b0, 7'd0, 1'b1};
			acc_word = '0;
			acc_count = 0;
			n = 1;
		end else begin
			diff = v ^ p;
			cnt = lead_nibbles(diff);
			len = MAX_CODE_BITS - 4 * cnt;
			room = (cap_bits >= bits_used) ? cap_bits - bits_used : 0;
			if (room < len) begin
				r[0] = OVERFLOWED;
				n = 1;
			end else begin
				bits_used += len;
				if (append_bits(WORD_W'(cnt), 4, w)) begin
					r[n] = '{w, 1'b1, 1'b0, LEN_W'(len), 1'b0};
					n++;
				end
				if (append_bits(diff, WORD_W - 4 * cnt, w)) begin
					r[n] = '{w, 1'b1, 1'b0, LEN_W'(len), 1'b0};
					n++;
				end
				if (n == 0) begin
					r[0] = '{64'd0, 1'b0, 1'b0, LEN_W'(len), 1'b0};
					n = 1;
				end
				r[n-1].lastf = 1'b1;
			end
		end
		if (keep)
			for (int k = 0; k < n; k++)
				due_q.push_back(r[k]);
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	task automatic send_word(input xnde_pkg::op_t o, input logic [WORD_W-1:0] v,
			input logic [WORD_W-1:0] p);
		in_valid <= 1'b1;
		op <= o;
		value_bits <= v;
		predictor_bits <= p;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic sender_gap();
		int g;
		int r;
		g = 0;
		r = $urandom_range(0, 99);
		if (!quiet_tx) begin
			if (r >= 95)
				g = $urandom_range(8, 30);
			else if (r >= 70)
				g = $urandom_range(1, 3);
		end
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_bits = c;
	endtask

	always @(posedge clk) begin : rx_pacing
		int r;
		r = $urandom_range(0, 99);
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (quiet_rx || r < 65) begin
			out_stall <= 1'b0;
		end else if (r < 95) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(10, 40);
		end
	end

	always @(posedge clk) begin : result_check
		stream_result_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (due_q.size() == 0) begin
				note_mismatch($sformatf({"Unexpected word: packed_word %h word_valid %b ",
					"status %b code_length %0d last %b"},
					packed_word, word_valid, status, code_length, last));
			end else begin
				due = due_q.pop_front();
				if (packed_word !== due.word || word_valid !== due.wvalid
						|| status !== due.stat || code_length !== due.clen
						|| last !== due.lastf)
					note_mismatch($sformatf({"Mismatch: expected %h/%b/%b/%0d/%b, ",
						"got %h/%b/%b/%0d/%b"}, due.word, due.wvalid, due.stat, due.clen,
						due.lastf, packed_word, word_valid, status, code_length, last));
			end
		end
	end

	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] d;
		logic [CAP_W-1:0] c;
		xnde_pkg::op_t o;
		cap_bits = CAPACITY_RESET;
		bits_used = 0;
		acc_word = '0;
		acc_count = 0;
		script = '{
			'{1'b0, 32'd0, xnde_pkg::OP_FLUSH, 64'd0, 64'd0, 1'b1, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, 64'd0, 64'd0, 1'b1, SHORT_CODE},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, ONES, 64'd0, 1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, 64'h8000_0000_0000_0000, 64'd0,
				1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, 64'd1, 64'd0, 1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, ONES, ONES, 1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, 64'h0123_4567_89AB_CDEF,
				64'hFEDC_BA98_7654_3210, 1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, 64'h0000_0F00_0000_0000, 64'd0,
				1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, 64'h0000_0000_0000_0010, 64'd0,
				1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_FLUSH, ONES, ONES, 1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_FLUSH, 64'd0, ONES, 1'b1, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, ONES, 64'h5555_5555_5555_5555,
				1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, 64'hAAAA_AAAA_AAAA_AAAA,
				64'h5555_5555_5555_5555, 1'b0, NO_WORD},
			'{1'b1, 32'd0, xnde_pkg::OP_ENCODE, 64'd0, 64'd0, 1'b1, OVERFLOWED},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, ONES, 64'd0, 1'b1, OVERFLOWED},
			'{1'b0, 32'd0, xnde_pkg::OP_FLUSH, 64'd0, 64'd0, 1'b0, NO_WORD},
			'{1'b1, 32'hFFFF_FFFF, xnde_pkg::OP_ENCODE, ONES, 64'd0, 1'b0, NO_WORD},
			'{1'b0, 32'd0, xnde_pkg::OP_ENCODE, 64'd0, 64'd0, 1'b0, NO_WORD},
			'{1'b1, CAPACITY_RESET, xnde_pkg::OP_FLUSH, 64'd0, 64'd0, 1'b0, NO_WORD}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].set_cap)
				write_capacity(script[i].cap);
			send_word(script[i].op, script[i].value, script[i].pred);
			encode_step(script[i].op, script[i].value, script[i].pred, !script[i].typed);
			if (script[i].typed)
				due_q.push_back(script[i].res);
			sender_gap();
		end

		// Capacity settings cycle through the extremes, a limit just above the bits already used
		// (so the room can run out exactly), one at or below it, a random value and the reset value.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 6)
				0: c = 32'hFFFF_FFFF;
				1: c = 32'd0;
				2: c = bits_used + 4 * $urandom_range(2, 17);
				3: c = bits_used - $urandom_range(0, (bits_used < 200) ? bits_used : 200);
				4: c = $urandom;
				default: c = CAPACITY_RESET;
			endcase
			write_capacity(c);
			quiet_tx = (ph % 3 == 1);
			quiet_rx = (ph % 4 == 2);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				o = ($urandom_range(0, 7) == 0) ? xnde_pkg::OP_FLUSH : xnde_pkg::OP_ENCODE;
				p = {$urandom, $urandom};
				d = {$urandom, $urandom} >> (4 * $urandom_range(0, 16));
				send_word(o, p ^ d, p);
				encode_step(o, p ^ d, p, 1'b1);
				sender_gap();
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_q.size() != 0)
			note_mismatch($sformatf("%0d expected words never arrived", due_q.size()));
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
